/* sv/plar_pkg.sv */
// shared types and constants for the polyline arc-length resampler
// used by plar_ctrl, plar_datapath and polyline_arc_length_resampler
`default_nettype none
package plar_pkg;

    localparam int DIST_W = 34;
    localparam int FRAC_W = 32;
    localparam logic [31:0] STEP_RESET = 32'h0001_0000;

    typedef enum logic [2:0] {
        OP_SQX  = 3'd0,
        OP_SQY  = 3'd1,
        OP_SQRT = 3'd2,
        OP_FRAC = 3'd3,
        OP_MULX = 3'd4,
        OP_MULY = 3'd5
    } plar_op_t;

    typedef enum logic [10:0] {
        ST_IDLE       = 11'b00000000001,
        ST_VTX        = 11'b00000000010,
        ST_SQX        = 11'b00000000100,
        ST_SQY        = 11'b00000001000,
        ST_SQRT       = 11'b00000010000,
        ST_EMIT_START = 11'b00000100000,
        ST_CHECK      = 11'b00001000000,
        ST_FRAC       = 11'b00010000000,
        ST_MULX       = 11'b00100000000,
        ST_MULY       = 11'b01000000000,
        ST_EMIT       = 11'b10000000000
    } plar_state_t;

    typedef struct packed {
        logic     load_vertex;
        logic     set_start;
        logic     commit;
        logic     op_start;
        plar_op_t op;
        logic     emit_start;
        logic     emit_point;
        logic     advance;
        logic     settle;
    } plar_cmd_t;

    typedef struct packed {
        logic busy;
        logic start_case;
        logic step_zero;
        logic seen_one;
        logic more;
        logic last;
        logic out_free;
    } plar_status_t;

endpackage
`default_nettype wire

/* sv/plar_datapath.sv */
// datapath: vertex and progress registers, shared shift-add multiplier,
// restoring square root and divider, output register; uses plar_pkg
`default_nettype none
module plar_datapath #(
    parameter int MAX_POINTS_PER_VERTEX = 64,
    parameter int COORD_WIDTH           = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire plar_pkg::plar_cmd_t         cmd,
    output plar_pkg::plar_status_t           status,
    input  wire logic                        in_new,
    input  wire logic [COORD_WIDTH-1:0]      in_x,
    input  wire logic [COORD_WIDTH-1:0]      in_y,
    input  wire logic                        cfg_we,
    input  wire logic [31:0]                 cfg_data,
    output logic [31:0]                      step_length,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [COORD_WIDTH-1:0]           out_x,
    output logic [COORD_WIDTH-1:0]           out_y,
    output logic                             out_last,
    output logic                             out_trunc
);
    localparam int CW   = COORD_WIDTH;
    localparam int LW   = CW + 1;
    localparam int FW   = plar_pkg::FRAC_W;
    localparam int DW   = plar_pkg::DIST_W;
    localparam int MB   = (LW > FW) ? LW : FW;
    localparam int PW   = (2 * LW + 1 > LW + FW) ? 2 * LW + 1 : LW + FW;
    localparam int SQW  = 2 * LW;
    localparam int RW   = LW + 3;
    localparam int CMPW = (LW > DW) ? LW : DW;
    localparam int ITW  = $clog2(MB + 1);
    localparam int CNTW = $clog2(MAX_POINTS_PER_VERTEX + 1);

    logic [31:0]        step_reg;
    logic [CW-1:0]      prev_x_reg, prev_y_reg, cur_x_reg, cur_y_reg;
    logic               new_reg;
    logic [1:0]         seen_reg;
    logic [DW-1:0]      dist_reg;
    logic [LW-1:0]      len_reg, pos_reg;
    logic [CNTW-1:0]    cnt_reg;
    logic [FW-1:0]      f_reg;
    logic [CW-1:0]      px_reg;
    logic [PW-1:0]      acc_reg, a_sh_reg;
    logic [MB-1:0]      b_sh_reg;
    logic [ITW-1:0]     it_reg;
    plar_pkg::plar_op_t op_reg;
    logic [SQW-1:0]     sq_sh_reg;
    logic [RW-1:0]      srem_reg;
    logic [LW-1:0]      root_reg;
    logic [LW:0]        r_reg;
    logic               out_valid_reg, out_last_reg, out_trunc_reg;
    logic [CW-1:0]      out_x_reg, out_y_reg;

    // differences and magnitudes
    logic signed [LW-1:0] dx, dy;
    logic [LW-1:0]        mx, my;
    assign dx = $signed({cur_x_reg[CW-1], cur_x_reg}) - $signed({prev_x_reg[CW-1], prev_x_reg});
    assign dy = $signed({cur_y_reg[CW-1], cur_y_reg}) - $signed({prev_y_reg[CW-1], prev_y_reg});
    assign mx = dx[LW-1] ? LW'(-dx) : LW'(dx);
    assign my = dy[LW-1] ? LW'(-dy) : LW'(dy);

    // progress compare
    logic [LW-1:0]   rem_w;
    logic [CMPW-1:0] rem_ext, dist_ext;
    logic            more, cap, last;
    assign rem_w    = len_reg - pos_reg;
    assign rem_ext  = CMPW'(rem_w);
    assign dist_ext = CMPW'(dist_reg);
    assign more     = rem_ext > dist_ext;
    assign cap      = (CNTW'(cnt_reg + 1'b1) == CNTW'(MAX_POINTS_PER_VERTEX));
    assign last     = !more || cap;

    // rounded interpolation from the accumulator
    logic [PW-1:0] rounded;
    logic [CW-1:0] off_w;
    logic [CW-1:0] interp_x, interp_y;
    assign rounded  = acc_reg + PW'(64'h8000_0000);
    assign off_w    = rounded[FW +: CW];
    assign interp_x = dx[LW-1] ? prev_x_reg - off_w : prev_x_reg + off_w;
    assign interp_y = dy[LW-1] ? prev_y_reg - off_w : prev_y_reg + off_w;

    // one step of each iterative unit
    logic [RW-1:0] srem_sh, trial;
    logic [LW:0]   r_sh;
    assign srem_sh = {srem_reg[RW-3:0], sq_sh_reg[SQW-1 -: 2]};
    assign trial   = RW'({root_reg, 2'b01});
    assign r_sh    = {r_reg[LW-1:0], 1'b0};

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= plar_pkg::STEP_RESET;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            seen_reg      <= '0;
            dist_reg      <= '0;
            it_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                step_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load_vertex) begin
                cur_x_reg <= in_x;
                cur_y_reg <= in_y;
                new_reg   <= in_new;
                pos_reg   <= '0;
                cnt_reg   <= '0;
            end
            if (cmd.set_start) begin
                prev_x_reg <= cur_x_reg;
                prev_y_reg <= cur_y_reg;
                seen_reg   <= 2'd1;
                dist_reg   <= DW'(step_reg);
            end
            if (cmd.commit) begin
                prev_x_reg <= cur_x_reg;
                prev_y_reg <= cur_y_reg;
                if (seen_reg != 2'd2) begin
                    seen_reg <= seen_reg + 2'd1;
                end
            end
            if (cmd.advance) begin
                pos_reg  <= LW'(CMPW'(pos_reg) + dist_ext);
                dist_reg <= DW'(step_reg);
            end
            if (cmd.settle) begin
                dist_reg <= DW'(dist_ext - rem_ext);
            end
            if (cmd.emit_start || cmd.emit_point) begin
                out_valid_reg <= 1'b1;
                out_x_reg     <= cmd.emit_start ? prev_x_reg : px_reg;
                out_y_reg     <= cmd.emit_start ? prev_y_reg : interp_y;
                out_last_reg  <= last;
                out_trunc_reg <= more && cap;
                cnt_reg       <= cnt_reg + 1'b1;
                if (!more) begin
                    dist_reg <= DW'(dist_ext - rem_ext);
                end
            end

            // shared iterative units
            if (cmd.op_start) begin
                op_reg <= cmd.op;
                it_reg <= ITW'(MB);
                case (cmd.op)
                    plar_pkg::OP_SQX: begin
                        acc_reg  <= '0;
                        a_sh_reg <= PW'(mx);
                        b_sh_reg <= MB'(mx);
                    end
                    plar_pkg::OP_SQY: begin
                        a_sh_reg <= PW'(my);
                        b_sh_reg <= MB'(my);
                    end
                    plar_pkg::OP_SQRT: begin
                        it_reg    <= ITW'(LW);
                        sq_sh_reg <= acc_reg[SQW-1:0];
                        srem_reg  <= '0;
                        root_reg  <= '0;
                    end
                    plar_pkg::OP_FRAC: begin
                        // starts together with the advance, so take the advanced position
                        it_reg <= ITW'(FW);
                        r_reg  <= (LW + 1)'(CMPW'(pos_reg) + dist_ext);
                        f_reg  <= '0;
                    end
                    plar_pkg::OP_MULX: begin
                        acc_reg  <= '0;
                        a_sh_reg <= PW'(mx);
                        b_sh_reg <= MB'(f_reg);
                    end
                    plar_pkg::OP_MULY: begin
                        px_reg   <= interp_x;
                        acc_reg  <= '0;
                        a_sh_reg <= PW'(my);
                        b_sh_reg <= MB'(f_reg);
                    end
                    default: begin
                        it_reg <= '0;
                    end
                endcase
            end else if (it_reg != '0) begin
                it_reg <= it_reg - 1'b1;
                case (op_reg)
                    plar_pkg::OP_SQRT: begin
                        sq_sh_reg <= {sq_sh_reg[SQW-3:0], 2'b00};
                        if (srem_sh >= trial) begin
                            srem_reg <= srem_sh - trial;
                            root_reg <= {root_reg[LW-2:0], 1'b1};
                        end else begin
                            srem_reg <= srem_sh;
                            root_reg <= {root_reg[LW-2:0], 1'b0};
                        end
                        if (it_reg == ITW'(1)) begin
                            len_reg <= (srem_sh >= trial) ? {root_reg[LW-2:0], 1'b1}
                                                          : {root_reg[LW-2:0], 1'b0};
                        end
                    end
                    plar_pkg::OP_FRAC: begin
                        if (r_sh >= {1'b0, len_reg}) begin
                            r_reg <= r_sh - {1'b0, len_reg};
                            f_reg <= {f_reg[FW-2:0], 1'b1};
                        end else begin
                            r_reg <= r_sh;
                            f_reg <= {f_reg[FW-2:0], 1'b0};
                        end
                    end
                    default: begin
                        if (b_sh_reg[0]) begin
                            acc_reg <= acc_reg + a_sh_reg;
                        end
                        a_sh_reg <= {a_sh_reg[PW-2:0], 1'b0};
                        b_sh_reg <= {1'b0, b_sh_reg[MB-1:1]};
                    end
                endcase
            end
        end
    end

    always_comb begin
        status.busy       = (it_reg != '0);
        status.start_case = new_reg || (seen_reg == 2'd0);
        status.step_zero  = (step_reg == 32'd0);
        status.seen_one   = (seen_reg == 2'd1);
        status.more       = more;
        status.last       = last;
        status.out_free   = out_free;
    end

    assign step_length = step_reg;
    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_last    = out_last_reg;
    assign out_trunc   = out_trunc_reg;

endmodule
`default_nettype wire

/* sv/plar_ctrl.sv */
// controller state machine sequencing one vertex through the datapath
// uses plar_pkg command and status types
`default_nettype none
module plar_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire plar_pkg::plar_status_t status,
    output plar_pkg::plar_cmd_t         cmd
);
    plar_pkg::plar_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= plar_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.op     = plar_pkg::OP_SQX;
        in_ready   = 1'b0;
        case (state_reg)
            plar_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_vertex = 1'b1;
                    state_next      = plar_pkg::ST_VTX;
                end
            end
            plar_pkg::ST_VTX: begin
                if (status.start_case) begin
                    cmd.set_start = 1'b1;
                    state_next    = plar_pkg::ST_IDLE;
                end else if (status.step_zero) begin
                    cmd.commit = 1'b1;
                    state_next = plar_pkg::ST_IDLE;
                end else begin
                    cmd.op_start = 1'b1;
                    cmd.op       = plar_pkg::OP_SQX;
                    state_next   = plar_pkg::ST_SQX;
                end
            end
            plar_pkg::ST_SQX: begin
                if (!status.busy) begin
                    cmd.op_start = 1'b1;
                    cmd.op       = plar_pkg::OP_SQY;
                    state_next   = plar_pkg::ST_SQY;
                end
            end
            plar_pkg::ST_SQY: begin
                if (!status.busy) begin
                    cmd.op_start = 1'b1;
                    cmd.op       = plar_pkg::OP_SQRT;
                    state_next   = plar_pkg::ST_SQRT;
                end
            end
            plar_pkg::ST_SQRT: begin
                if (!status.busy) begin
                    state_next = status.seen_one ? plar_pkg::ST_EMIT_START
                                                 : plar_pkg::ST_CHECK;
                end
            end
            plar_pkg::ST_EMIT_START: begin
                if (status.out_free) begin
                    cmd.emit_start = 1'b1;
                    if (status.last) begin
                        cmd.commit = 1'b1;
                        state_next = plar_pkg::ST_IDLE;
                    end else begin
                        state_next = plar_pkg::ST_CHECK;
                    end
                end
            end
            plar_pkg::ST_CHECK: begin
                if (status.more) begin
                    cmd.advance  = 1'b1;
                    cmd.op_start = 1'b1;
                    cmd.op       = plar_pkg::OP_FRAC;
                    state_next   = plar_pkg::ST_FRAC;
                end else begin
                    cmd.settle = 1'b1;
                    cmd.commit = 1'b1;
                    state_next = plar_pkg::ST_IDLE;
                end
            end
            plar_pkg::ST_FRAC: begin
                if (!status.busy) begin
                    cmd.op_start = 1'b1;
                    cmd.op       = plar_pkg::OP_MULX;
                    state_next   = plar_pkg::ST_MULX;
                end
            end
            plar_pkg::ST_MULX: begin
                if (!status.busy) begin
                    cmd.op_start = 1'b1;
                    cmd.op       = plar_pkg::OP_MULY;
                    state_next   = plar_pkg::ST_MULY;
                end
            end
            plar_pkg::ST_MULY: begin
                if (!status.busy) begin
                    state_next = plar_pkg::ST_EMIT;
                end
            end
            plar_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_point = 1'b1;
                    if (status.last) begin
                        cmd.commit = 1'b1;
                        state_next = plar_pkg::ST_IDLE;
                    end else begin
                        state_next = plar_pkg::ST_CHECK;
                    end
                end
            end
            default: begin
                state_next = plar_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* sv/polyline_arc_length_resampler.sv */
// top level of the polyline arc-length resampler: stream and apb ports
// instantiates plar_ctrl and plar_datapath, uses plar_pkg
//
// usage
//   vertices enter on the s_ stream: s_tdata = {vertex_y, vertex_x}, s_tuser = new_polyline
//   sample points leave on the m_ stream: m_tdata = {point_y, point_x},
//   m_tlast = last_of_run, m_tuser = truncated
//   step_length (unsigned q16.16) is written over apb at byte address 0; the user must
//   write it only while idle, which the block itself leaves unenforced
// sequencing
//   one vertex at a time; a start vertex or a zero step only records the vertex
//   a segment squares both differences on the shift-add multiplier and then runs the
//   bit-per-cycle square root up to its first sample check; each sample point then takes
//   32 divider steps for the fraction and one shift-add product per axis
// reset
//   synchronous active-low aresetn clears the previous vertex, the seen-vertex count, the
//   carried distance and the output valid flag; step_length returns to 1.0
// back-pressure
//   a point sits in the output register until taken; the sequencer stalls only when it
//   has a newer point and that register is still full
`default_nettype none
module polyline_arc_length_resampler #(
    parameter int MAX_POINTS_PER_VERTEX = 64,
    parameter int COORD_WIDTH           = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // vertex transactions
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,  // vertex_x, vertex_y
    input  wire logic                              s_tuser,  // new_polyline
    // point transactions
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,  // point_x, point_y
    output logic                                   m_tlast,  // last_of_run
    output logic                                   m_tuser,  // truncated
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [2:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    localparam int CW = COORD_WIDTH;
    localparam int TW = ((2 * CW + 7) / 8) * 8;

    plar_pkg::plar_cmd_t    cmd;
    plar_pkg::plar_status_t status;
    logic                   cfg_we;
    logic [31:0]            step_length;
    logic [CW-1:0]          out_x, out_y;

    // register write on the apb access phase, step_length is the only register
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == 3'd0);
    assign prdata = (paddr == 3'd0) ? step_length : 32'd0;

    plar_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    plar_datapath #(
        .MAX_POINTS_PER_VERTEX (MAX_POINTS_PER_VERTEX),
        .COORD_WIDTH           (COORD_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_new      (s_tuser),
        .in_x        (s_tdata[CW-1:0]),
        .in_y        (s_tdata[2*CW-1:CW]),
        .cfg_we      (cfg_we),
        .cfg_data    (pwdata),
        .step_length (step_length),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_last    (m_tlast),
        .out_trunc   (m_tuser)
    );

    // pad the point pair up to whole bytes
    assign m_tdata = TW'({out_y, out_x});

endmodule
`default_nettype wire
